@@ hw/rtl/ptt_pkg.sv @@
`timescale 1ns / 1ps
package ptt_pkg;
   localparam int SLOTS            = 16;
   localparam int SLOT_W           = 4;
   localparam int PRIO_W           = 8;
   localparam int CNT_W            = 5;
   localparam int DEF_HANDLE_BITS  = 32;
   localparam int RSP_W            = 16;

   typedef enum logic [2:0] {
      CMD_CREATE  = 3'd0,
      CMD_DESTROY = 3'd1,
      CMD_WALK    = 3'd2,
      CMD_FIND    = 3'd3,
      CMD_COUNT   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } state_type;

   // one cell's visible entry
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
   } cell_ctl_type;
endpackage

@@ hw/rtl/ptt_cell.sv @@
`timescale 1ns / 1ps
module ptt_cell #(
   parameter int HANDLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_pkg::cell_ctl_type ctl,
   input  logic [HANDLE_BITS-1:0] key_handle,
   input  ptt_pkg::entry_type    up_entry,
   input  logic [HANDLE_BITS-1:0] up_handle,
   input  logic                  up_go,
   input  ptt_pkg::entry_type    dn_entry,
   input  logic [HANDLE_BITS-1:0] dn_handle,
   input  logic                  kill_in,
   output ptt_pkg::entry_type    entry,
   output logic [HANDLE_BITS-1:0] handle,
   output logic                  go,
   output logic                  kill_out,
   output logic                  match
);
   import ptt_pkg::*;

   logic                   valid_ff, valid_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [PRIO_W-1:0]      prio_ff, prio_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // insertion point and removal prefix
   assign go       = !(valid_ff && (prio_ff <= ctl.prio));
   assign kill_out = kill_in || (valid_ff && (slot_ff == ctl.slot));
   assign match    = valid_ff && (handle_ff == key_handle);
   assign entry    = '{valid: valid_ff, slot: slot_ff, prio: prio_ff};
   assign handle   = handle_ff;

   // next contents: keep, shift down, take new, or shift up
   always_comb begin
      valid_in  = valid_ff;
      slot_in   = slot_ff;
      prio_in   = prio_ff;
      handle_in = handle_ff;
      if (ctl.ins && go) begin
         if (up_go) begin
            valid_in  = up_entry.valid;
            slot_in   = up_entry.slot;
            prio_in   = up_entry.prio;
            handle_in = up_handle;
         end else begin
            valid_in  = 1'b1;
            slot_in   = ctl.slot;
            prio_in   = ctl.prio;
            handle_in = key_handle;
         end
      end else if (ctl.del && kill_out) begin
         valid_in  = dn_entry.valid;
         slot_in   = dn_entry.slot;
         prio_in   = dn_entry.prio;
         handle_in = dn_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      prio_ff   <= prio_in;
      handle_ff <= handle_in;
   end
endmodule

@@ hw/rtl/priority_task_table.sv @@
`timescale 1ns / 1ps
// priority task table: 16 task slots kept in run order
// req channel carries one command (create, destroy, walk, find, count);
// rsp channel returns its results, rsp_tlast on the final one.
// the order is held in a row of cells sorted by priority, lower value first,
// equal values in order of arrival; an insert or removal shifts the cells
// by one place, all in the same cycle, each cell taking its neighbour's entry.
// a command is accepted and its first result is registered on the same
// edge, so the result is visible in the cycle after the transfer.
// create, destroy, find and count give one result each; walk gives one result
// per active slot, one result per cycle while rsp_tready does not stall, set by
// the single output register the walk index reads through.
// a new command is taken only once the previous command's results are all
// queued; a stalled rsp_tready holds the result register and the walk.
// reset empties the table: all slots inactive, count zero.
module priority_task_table #(
   parameter int HANDLE_BITS = ptt_pkg::DEF_HANDLE_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // cmd[3], slot[4], prio[8], handle[HANDLE_BITS], zero fill
   input  logic [((15 + HANDLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[2], slot_out[4], active_count[5], zero fill
   output logic [ptt_pkg::RSP_W-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import ptt_pkg::*;

   cmd_type                 cmd;
   logic [SLOT_W-1:0]       req_slot;
   logic [PRIO_W-1:0]       req_prio;
   logic [HANDLE_BITS-1:0]  req_handle;

   assign cmd        = cmd_type'(req_tdata[2:0]);
   assign req_slot   = req_tdata[6:3];
   assign req_prio   = req_tdata[14:7];
   assign req_handle = req_tdata[15 +: HANDLE_BITS];

   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               rv_ff, rv_in;
   status_type         rst_ff, rst_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in;
   logic [CNT_W-1:0]   rcnt_ff, rcnt_in;
   logic               rlast_ff, rlast_in;

   cell_ctl_type       ctl;
   entry_type          ent [SLOTS];
   logic [HANDLE_BITS-1:0] hnd [SLOTS];
   logic [SLOTS-1:0]   go_v, kill_v, match_v;
   logic [SLOTS-1:0]   found_v;
   logic               free_any, found_any, rsp_free, accept;
   logic [SLOT_W-1:0]  free_slot, found_slot;

   // row of cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      entry_type              up_e, dn_e;
      logic [HANDLE_BITS-1:0] up_h, dn_h;
      logic                   up_g, k_in;
      if (g == 0) begin : g_first
         assign up_e = '0;
         assign up_h = '0;
         assign up_g = 1'b0;
         assign k_in = 1'b0;
      end else begin : g_mid
         assign up_e = ent[g-1];
         assign up_h = hnd[g-1];
         assign up_g = go_v[g-1];
         assign k_in = kill_v[g-1];
      end
      if (g == SLOTS - 1) begin : g_last
         assign dn_e = '0;
         assign dn_h = '0;
      end else begin : g_inner
         assign dn_e = ent[g+1];
         assign dn_h = hnd[g+1];
      end
      ptt_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key_handle (req_handle),
         .up_entry   (up_e),
         .up_handle  (up_h),
         .up_go      (up_g),
         .dn_entry   (dn_e),
         .dn_handle  (dn_h),
         .kill_in    (k_in),
         .entry      (ent[g]),
         .handle     (hnd[g]),
         .go         (go_v[g]),
         .kill_out   (kill_v[g]),
         .match      (match_v[g])
      );
   end

   // lowest free slot and lowest matching slot
   always_comb begin
      found_v = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match_v[i]) begin
            found_v[ent[i].slot] = 1'b1;
         end
      end
      free_any   = 1'b0;
      free_slot  = '0;
      found_any  = 1'b0;
      found_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(i);
         end
         if (found_v[i]) begin
            found_any  = 1'b1;
            found_slot = SLOT_W'(i);
         end
      end
   end

   assign rsp_free   = !rv_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;

   // sequencer and result register
   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      rv_in     = rv_ff && !rsp_tready;
      rst_in    = rst_ff;
      rslot_in  = rslot_ff;
      rcnt_in   = rcnt_ff;
      rlast_in  = rlast_ff;
      ctl       = '{ins: 1'b0, del: 1'b0, slot: req_slot, prio: req_prio};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rv_in    = 1'b1;
               rst_in   = ST_OK;
               rslot_in = '0;
               rcnt_in  = '0;
               rlast_in = 1'b1;
               case (cmd)
                  CMD_CREATE: begin
                     if (free_any) begin
                        ctl.ins              = 1'b1;
                        ctl.slot             = free_slot;
                        active_in[free_slot] = 1'b1;
                        cnt_in               = cnt_ff + CNT_W'(1);
                        rslot_in             = free_slot;
                     end else begin
                        rst_in = ST_FULL;
                     end
                  end
                  CMD_DESTROY: begin
                     rslot_in = req_slot;
                     if (active_ff[req_slot]) begin
                        ctl.del             = 1'b1;
                        active_in[req_slot] = 1'b0;
                        cnt_in              = cnt_ff - CNT_W'(1);
                     end else begin
                        rst_in = ST_NOTFOUND;
                     end
                  end
                  CMD_WALK: begin
                     if (cnt_ff == '0) begin
                        rst_in = ST_EMPTY;
                     end else begin
                        rslot_in = ent[0].slot;
                        rlast_in = (cnt_ff == CNT_W'(1));
                        idx_in   = SLOT_W'(1);
                        if (cnt_ff != CNT_W'(1)) begin
                           state_in = S_WALK;
                        end
                     end
                  end
                  CMD_FIND: begin
                     if (found_any) begin
                        rslot_in = found_slot;
                     end else begin
                        rst_in = ST_NOTFOUND;
                     end
                  end
                  CMD_COUNT: begin
                     rcnt_in = cnt_ff;
                  end
                  default: begin
                     rst_in = ST_NOTFOUND;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (rsp_free) begin
               rv_in    = 1'b1;
               rst_in   = ST_OK;
               rslot_in = ent[idx_ff].slot;
               rcnt_in  = '0;
               rlast_in = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
               idx_in   = idx_ff + SLOT_W'(1);
               if (rlast_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rst_ff   <= rst_in;
      rslot_ff <= rslot_in;
      rcnt_ff  <= rcnt_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {{(RSP_W - 11){1'b0}}, rcnt_ff, rslot_ff, rst_ff};

   // checks
   logic [SLOTS-1:0] cell_valid_v;
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cell_valid_v[i] = ent[i].valid;
      end
   end

   a_cnt_active: assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(active_ff)) == cnt_ff)
      else $error("count differs from active slots");
   a_cnt_cells: assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(cell_valid_v)) == cnt_ff)
      else $error("cell row out of step with count");
   a_walk_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (CNT_W'(idx_ff) < cnt_ff))
      else $error("walk index beyond list");
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rv_ff)
      else $error("accepted command gave no result");
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import ptt_pkg::*;

   localparam int HANDLE_BITS = 32;
   localparam int REQ_W = ((15 + HANDLE_BITS + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] CMD_BAD_5 = 3'd5;
   localparam logic [2:0] CMD_BAD_7 = 3'd7;
   localparam logic [7:0] HEAD_MARK = 8'hFE;
   localparam logic [7:0] TAIL_MARK = 8'hFF;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot_out;
      logic [4:0] active_count;
      logic       last;
   } task_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;

   // shadow copy of the task table
   logic        tbl_active [SLOTS];
   logic [7:0]  tbl_prev [SLOTS];
   logic [7:0]  tbl_next [SLOTS];
   logic [7:0]  tbl_prio [SLOTS];
   logic [31:0] tbl_handle [SLOTS];

   task_result_type pending_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit drain_on = 0;

   priority_task_table #(.HANDLE_BITS(HANDLE_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 4) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_active[i] = 1'b0;
         tbl_prev[i] = (i == 0) ? HEAD_MARK : 8'(i - 1);
         tbl_next[i] = (i == SLOTS - 1) ? TAIL_MARK : 8'(i + 1);
         tbl_prio[i] = 8'hFF;
         tbl_handle[i] = '0;
      end
   endfunction

   function automatic int head_of_list();
      for (int i = 0; i < SLOTS; i++)
         if (tbl_active[i] && tbl_prev[i] == HEAD_MARK) return i;
      return SLOTS;
   endfunction

   function automatic void push_result(logic [1:0] st, int s, int cnt, bit lst);
      task_result_type r;
      r.status = st;
      r.slot_out = 4'(s);
      r.active_count = 5'(cnt);
      r.last = lst;
      pending_results.push_back(r);
   endfunction

   // insert slot n after every entry of lower or equal priority
   function automatic void link_slot(int n);
      int cur;
      logic [7:0] p;
      cur = head_of_list();
      if (cur >= SLOTS) begin
         tbl_prev[n] = HEAD_MARK;
         tbl_next[n] = TAIL_MARK;
         return;
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (tbl_prio[n] < tbl_prio[cur]) begin
            p = tbl_prev[cur];
            tbl_prev[n] = p;
            tbl_next[n] = 8'(cur);
            if (p < SLOTS) tbl_next[p] = 8'(n);
            tbl_prev[cur] = 8'(n);
            return;
         end
         if (tbl_next[cur] >= SLOTS) begin
            tbl_prev[n] = 8'(cur);
            tbl_next[n] = TAIL_MARK;
            tbl_next[cur] = 8'(n);
            return;
         end
         cur = tbl_next[cur];
      end
      tbl_prev[n] = HEAD_MARK;
      tbl_next[n] = TAIL_MARK;
   endfunction

   // work out the results of one command and update the shadow table
   function automatic void predict_command(logic [2:0] cmd, logic [3:0] slot,
                                           logic [7:0] prio, logic [31:0] handle);
      int cur, k, cnt, nx;
      logic [7:0] p, n;
      case (cmd)
         CMD_CREATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (!tbl_active[i]) begin
                  tbl_handle[i] = handle;
                  tbl_prio[i] = prio;
                  link_slot(i);
                  tbl_active[i] = 1'b1;
                  push_result(ST_OK, i, 0, 1);
                  return;
               end
            push_result(ST_FULL, 0, 0, 1);
         end
         CMD_DESTROY: begin
            if (!tbl_active[slot]) begin
               push_result(ST_NOTFOUND, slot, 0, 1);
               return;
            end
            tbl_active[slot] = 1'b0;
            p = tbl_prev[slot];
            n = tbl_next[slot];
            if (p >= SLOTS) begin
               if (n < SLOTS) tbl_prev[n] = HEAD_MARK;
            end else if (n >= SLOTS) begin
               tbl_next[p] = TAIL_MARK;
            end else begin
               tbl_next[p] = n;
               tbl_prev[n] = p;
            end
            push_result(ST_OK, slot, 0, 1);
         end
         CMD_WALK: begin
            cur = head_of_list();
            k = 0;
            if (cur >= SLOTS) begin
               push_result(ST_EMPTY, 0, 0, 1);
               return;
            end
            while (cur < SLOTS && k < SLOTS) begin
               nx = tbl_next[cur];
               push_result(ST_OK, cur, 0, (nx >= SLOTS) || (k + 1 >= SLOTS));
               k++;
               cur = nx;
            end
         end
         CMD_FIND: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_active[i] && tbl_handle[i] == handle) begin
                  push_result(ST_OK, i, 0, 1);
                  return;
               end
            push_result(ST_NOTFOUND, 0, 0, 1);
         end
         CMD_COUNT: begin
            cnt = 0;
            for (int i = 0; i < SLOTS; i++) if (tbl_active[i]) cnt++;
            push_result(ST_OK, 0, cnt, 1);
         end
         default: push_result(ST_NOTFOUND, 0, 0, 1);
      endcase
   endfunction

   // send one command, predicting at the accepting edge
   // tvalid stays high into a back-to-back transfer and drops only for a gap
   task automatic send_command(logic [2:0] cmd, logic [3:0] slot,
                               logic [7:0] prio, logic [31:0] handle);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({handle, prio, slot, cmd});
      do @(posedge clock); while (!req_tready);
      predict_command(cmd, slot, prio, handle);
   endtask

   function automatic int live_handle();
      int idx[$];
      for (int i = 0; i < SLOTS; i++) if (tbl_active[i]) idx.push_back(i);
      if (idx.size() == 0) return $urandom();
      return tbl_handle[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   task automatic test_empty_table();
      send_command(CMD_WALK, 4'd0, 8'd0, 32'd0);
      send_command(CMD_COUNT, 4'd0, 8'd0, 32'd0);
      send_command(CMD_FIND, 4'd0, 8'd0, 32'd0);
      send_command(CMD_DESTROY, 4'd15, 8'd0, 32'd0);
      send_command(CMD_BAD_5, 4'd15, 8'hFF, 32'hFFFF_FFFF);
      send_command(CMD_BAD_7, 4'd0, 8'd0, 32'd0);
   endtask

   task automatic test_fill_and_order();
      // extremes of priority, equal priorities keep arrival order
      send_command(CMD_CREATE, 4'd0, 8'hFF, 32'hFFFF_FFFF);
      send_command(CMD_CREATE, 4'd0, 8'h00, 32'h0000_0000);
      send_command(CMD_CREATE, 4'd0, 8'h80, 32'hA5A5_5A5A);
      send_command(CMD_CREATE, 4'd0, 8'h80, 32'hA5A5_5A5A);
      for (int i = 4; i < SLOTS; i++)
         send_command(CMD_CREATE, 4'd0, 8'($urandom_range(0, 3) * 85), $urandom());
      send_command(CMD_CREATE, 4'd0, 8'd1, 32'd1);
      send_command(CMD_WALK, 4'd0, 8'd0, 32'd0);
      send_command(CMD_COUNT, 4'd0, 8'd0, 32'd0);
      send_command(CMD_FIND, 4'd0, 8'd0, 32'hA5A5_5A5A);
   endtask

   task automatic test_unlink();
      send_command(CMD_DESTROY, 4'd1, 8'd0, 32'd0);
      send_command(CMD_DESTROY, 4'd0, 8'd0, 32'd0);
      send_command(CMD_DESTROY, 4'd0, 8'd0, 32'd0);
      send_command(CMD_WALK, 4'd0, 8'd0, 32'd0);
      for (int i = 0; i < SLOTS; i++) send_command(CMD_DESTROY, 4'(i), 8'd0, 32'd0);
      send_command(CMD_WALK, 4'd0, 8'd0, 32'd0);
   endtask

   task automatic test_random_mix();
      int r;
      logic [31:0] h;
      for (int n = 0; n < 400; n++) begin
         r = $urandom_range(0, 99);
         h = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($urandom_range(0, 7));
         if (r < 35) send_command(CMD_CREATE, 4'($urandom()), 8'($urandom()), h);
         else if (r < 60) send_command(CMD_DESTROY, 4'($urandom()), 8'($urandom()), h);
         else if (r < 72) send_command(CMD_WALK, 4'($urandom()), 8'($urandom()), h);
         else if (r < 84)
            send_command(CMD_FIND, 4'($urandom()), 8'($urandom()), 32'(live_handle()));
         else if (r < 90) send_command(CMD_FIND, 4'($urandom()), 8'($urandom()), h);
         else if (r < 97) send_command(CMD_COUNT, 4'($urandom()), 8'($urandom()), h);
         else send_command(3'($urandom_range(5, 7)), 4'($urandom()), 8'($urandom()), h);
      end
   endtask

   // random stall on the result side
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (drain_on) begin
            rsp_tready <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      task_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.slot_out = rsp_tdata[5:2];
         got.active_count = rsp_tdata[10:6];
         got.last = rsp_tlast;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want || rsp_tdata[15:11] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[priority_task_table] ERROR");
         $finish;
      end
   end

   initial begin
      table_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_fill_and_order();
      test_unlink();
      test_random_mix();
      req_tvalid <= 1'b0;
      drain_on = 1;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("[priority_task_table] OK");
      else
         $display("[priority_task_table] ERROR");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_cell.sv
hw/rtl/priority_task_table.sv
sim/tb_top.sv
